// File: hw/rtl/slti_pkg.sv
// ----------------------------------------------------------------------------
// slti_pkg: shared types and constants for the sorted table interpolator
// Function codes, status codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package slti_pkg;

    localparam int KEY_WIDTH           = 16;
    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DEFAULT_VALUE_WIDTH = 16;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_TOO_FEW    = 3'd2,
        ST_EXTRAP     = 3'd3,
        ST_DEGENERATE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEL,
        S_GATHER,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_FIN
    } state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic ins_en;  // insert key/value into the sorted chain
        logic cmp_en;  // capture compare flags against the key
        logic sel_en;  // capture the selected segment
        logic hit;     // select first exact match
        logic below;   // select the first segment
        logic above;   // select the last segment
    } cell_ctrl_t;

endpackage

// File: hw/rtl/slti_cell.sv
// ----------------------------------------------------------------------------
// slti_cell: one entry of the sorted point chain
// Holds one (x, y) point, shifts toward higher index on insert, and flags
// its relation to the current key for the bracket search.
// ----------------------------------------------------------------------------
module slti_cell #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = slti_pkg::DEFAULT_VALUE_WIDTH,
    parameter int CW          = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  slti_pkg::cell_ctrl_t                 ctrl,
    input  logic [CW-1:0]                        count,
    input  logic signed [slti_pkg::KEY_WIDTH-1:0] key,
    input  logic signed [VALUE_WIDTH-1:0]        val,
    input  logic signed [slti_pkg::KEY_WIDTH-1:0] prev_x,
    input  logic signed [VALUE_WIDTH-1:0]        prev_y,
    input  logic                                 prev_gt,
    input  logic                                 prev_eq,
    input  logic signed [slti_pkg::KEY_WIDTH-1:0] up_x,
    input  logic signed [VALUE_WIDTH-1:0]        up_y,
    input  logic                                 up_lt,
    output logic signed [slti_pkg::KEY_WIDTH-1:0] x,
    output logic signed [VALUE_WIDTH-1:0]        y,
    output logic                                 gt,
    output logic                                 lt,
    output logic                                 eq,
    output logic                                 pick,
    output logic signed [slti_pkg::KEY_WIDTH-1:0] pick_xl,
    output logic signed [VALUE_WIDTH-1:0]        pick_yl,
    output logic signed [slti_pkg::KEY_WIDTH-1:0] pick_xu,
    output logic signed [VALUE_WIDTH-1:0]        pick_yu
);

    localparam logic [CW-1:0] IDX    = CW'(INDEX);
    localparam logic [CW:0]   IDX_P2 = (CW+1)'(INDEX + 2);

    logic signed [slti_pkg::KEY_WIDTH-1:0] x_reg, x_next;
    logic signed [VALUE_WIDTH-1:0]         y_reg, y_next;
    logic lt_reg, eq_reg, pick_reg;
    logic signed [slti_pkg::KEY_WIDTH-1:0] pxl_reg, pxu_reg;
    logic signed [VALUE_WIDTH-1:0]         pyl_reg, pyu_reg;
    logic valid, at_end, first_eq, lower, sel;

    assign valid  = IDX < count;
    assign at_end = IDX == count;
    assign gt     = valid && (x_reg > key);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (ctrl.ins_en)
        begin
            if (prev_gt)
            begin
                x_next = prev_x;
                y_next = prev_y;
            end
            else if (gt || at_end)
            begin
                x_next = key;
                y_next = val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    // lower end of the bracketing segment
    assign first_eq = eq_reg && !prev_eq;
    always_comb
    begin
        if (ctrl.below)
            lower = (INDEX == 0);
        else if (ctrl.above)
            lower = ({1'b0, count} == IDX_P2);
        else
            lower = lt_reg && !up_lt;
    end
    assign sel = ctrl.hit ? first_eq : lower;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg   <= 1'b0;
            eq_reg   <= 1'b0;
            pick_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp_en)
            begin
                lt_reg <= valid && (x_reg < key);
                eq_reg <= valid && (x_reg == key);
            end
            if (ctrl.sel_en)
                pick_reg <= sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sel_en)
        begin
            pxl_reg <= sel ? x_reg : '0;
            pyl_reg <= sel ? y_reg : '0;
            pxu_reg <= sel ? up_x  : '0;
            pyu_reg <= sel ? up_y  : '0;
        end
    end

    assign x       = x_reg;
    assign y       = y_reg;
    assign lt      = lt_reg;
    assign eq      = eq_reg;
    assign pick    = pick_reg;
    assign pick_xl = pxl_reg;
    assign pick_yl = pyl_reg;
    assign pick_xu = pxu_reg;
    assign pick_yu = pyu_reg;

endmodule

// File: hw/rtl/slti_div.sv
// ----------------------------------------------------------------------------
// slti_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module slti_div #(
    parameter int NW = 34,
    parameter int DW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   nq_reg;
    logic [DW-1:0]   d_reg;
    logic [DW-1:0]   rem_reg;
    logic            neg_reg;
    logic            busy_reg, done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW:0]     trial;
    logic            fits;

    assign trial = {rem_reg, nq_reg[NW-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num[NW-1] ? -num : num;
            d_reg   <= den[DW-1] ? -den : den;
            rem_reg <= '0;
            neg_reg <= num[NW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
            nq_reg  <= {nq_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(nq_reg) : $signed(nq_reg);

endmodule

// File: hw/rtl/sorted_table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator: piecewise linear lookup over sorted points
// Each request is handled alone. A load, clear or unused code goes through
// S_EXEC and S_FIN; a query that matches or needs no arithmetic runs S_EXEC,
// S_SEL, S_GATHER and S_FIN, and an interpolating query goes on from S_GATHER
// through S_MUL, S_DIVGO and S_DIV, set by the one-bit-per-cycle divider.
// Points live in a chain of TABLE_DEPTH cells kept sorted by x; an insert
// shifts the tail of the chain by one cell, all cells at once. A new request
// can be accepted while the previous result is still waiting to be taken.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator #(
    parameter int TABLE_DEPTH = slti_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = slti_pkg::DEFAULT_VALUE_WIDTH,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           func,
    input  logic signed [slti_pkg::KEY_WIDTH-1:0] key_x,
    input  logic signed [VALUE_WIDTH-1:0]        value_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [VALUE_WIDTH-1:0]        result_y,
    output logic [2:0]                           status,
    output logic                                 matched,
    output logic [CW-1:0]                        entries
);

    localparam int KW = slti_pkg::KEY_WIDTH;
    localparam int NW = KW + VALUE_WIDTH + 2;
    localparam int DW = KW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic signed [NW:0] SAT_MAX = (NW+1)'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
    localparam logic signed [NW:0] SAT_MIN = -SAT_MAX - 1;

    slti_pkg::state_t state_reg, state_next;
    slti_pkg::cell_ctrl_t ctrl;

    logic [1:0]                func_reg;
    logic signed [KW-1:0]      key_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic                      hit_reg, below_reg, above_reg;
    logic signed [KW-1:0]      xl_reg, xu_reg;
    logic signed [VALUE_WIDTH-1:0] yl_reg, yu_reg;
    logic signed [NW-1:0]      prod_reg;
    logic signed [DW-1:0]      den_reg;
    logic signed [VALUE_WIDTH-1:0] res_reg, res_next;
    slti_pkg::status_t         stat_reg, stat_next;
    logic                      match_reg, match_next;

    logic                      out_valid_reg;
    logic signed [VALUE_WIDTH-1:0] out_y_reg;
    logic [2:0]                out_stat_reg;
    logic                      out_match_reg;
    logic [CW-1:0]             out_cnt_reg;

    logic signed [KW-1:0]          cx   [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] cy   [TABLE_DEPTH];
    logic signed [KW-1:0]          pxl  [TABLE_DEPTH];
    logic signed [KW-1:0]          pxu  [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] pyl  [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] pyu  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]        cgt, clt, ceq, cpick, cvalid;

    logic                      any_eq, all_lt;
    logic signed [KW-1:0]      g_xl, g_xu;
    logic signed [VALUE_WIDTH-1:0] g_yl, g_yu;
    logic                      div_done;
    logic signed [NW-1:0]      quo;
    logic signed [NW:0]        sum;
    logic                      fin_go;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic signed [KW-1:0]          p_x, u_x;
        logic signed [VALUE_WIDTH-1:0] p_y, u_y;
        logic                          p_gt, p_eq, u_lt;
        if (i == 0)
        begin : g_first
            assign p_x  = '0;
            assign p_y  = '0;
            assign p_gt = 1'b0;
            assign p_eq = 1'b0;
        end
        else
        begin : g_mid
            assign p_x  = cx[i-1];
            assign p_y  = cy[i-1];
            assign p_gt = cgt[i-1];
            assign p_eq = ceq[i-1];
        end
        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign u_x  = '0;
            assign u_y  = '0;
            assign u_lt = 1'b0;
        end
        else
        begin : g_up
            assign u_x  = cx[i+1];
            assign u_y  = cy[i+1];
            assign u_lt = clt[i+1];
        end
        assign cvalid[i] = CW'(i) < count_reg;

        slti_cell #(
            .INDEX      (i),
            .VALUE_WIDTH(VALUE_WIDTH),
            .CW         (CW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .count  (count_reg),
            .key    (key_reg),
            .val    (val_reg),
            .prev_x (p_x),
            .prev_y (p_y),
            .prev_gt(p_gt),
            .prev_eq(p_eq),
            .up_x   (u_x),
            .up_y   (u_y),
            .up_lt  (u_lt),
            .x      (cx[i]),
            .y      (cy[i]),
            .gt     (cgt[i]),
            .lt     (clt[i]),
            .eq     (ceq[i]),
            .pick   (cpick[i]),
            .pick_xl(pxl[i]),
            .pick_yl(pyl[i]),
            .pick_xu(pxu[i]),
            .pick_yu(pyu[i])
        );
    end

    // picks are zero except at the one selected cell
    always_comb
    begin
        any_eq = 1'b0;
        all_lt = 1'b1;
        g_xl   = '0;
        g_xu   = '0;
        g_yl   = '0;
        g_yu   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            any_eq = any_eq | ceq[i];
            all_lt = all_lt & (clt[i] | !cvalid[i]);
            g_xl   = g_xl | pxl[i];
            g_xu   = g_xu | pxu[i];
            g_yl   = g_yl | pyl[i];
            g_yu   = g_yu | pyu[i];
        end
    end

    slti_div #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(state_reg == slti_pkg::S_DIVGO),
        .num  (prod_reg),
        .den  (den_reg),
        .done (div_done),
        .quo  (quo)
    );

    assign sum = (NW+1)'(yl_reg) + (NW+1)'(quo);

    // ---------------- control ----------------
    assign fin_go   = !out_valid_reg || out_ready;
    assign in_ready = state_reg == slti_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        match_next = match_reg;
        ctrl       = '0;
        ctrl.hit   = hit_reg;
        ctrl.below = below_reg;
        ctrl.above = above_reg;
        case (state_reg)
            slti_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = slti_pkg::S_EXEC;
                res_next   = '0;
                stat_next  = slti_pkg::ST_OK;
                match_next = 1'b0;
            end
            slti_pkg::S_EXEC:
            begin
                state_next = slti_pkg::S_FIN;
                case (func_reg)
                    slti_pkg::FUNC_LOAD:
                    begin
                        if (count_reg == DEPTH_C)
                            stat_next = slti_pkg::ST_FULL;
                        else
                        begin
                            ctrl.ins_en = 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    slti_pkg::FUNC_QUERY:
                    begin
                        ctrl.cmp_en = 1'b1;
                        state_next  = slti_pkg::S_SEL;
                    end
                    slti_pkg::FUNC_CLEAR: count_next = '0;
                    default: ;
                endcase
            end
            slti_pkg::S_SEL:
            begin
                ctrl.sel_en = 1'b1;
                ctrl.hit    = any_eq;
                ctrl.below  = !any_eq && (count_reg < CW'(2) || !clt[0]);
                ctrl.above  = !any_eq && count_reg >= CW'(2) && all_lt;
                state_next  = slti_pkg::S_GATHER;
            end
            slti_pkg::S_GATHER:
            begin
                state_next = slti_pkg::S_FIN;
                if (hit_reg)
                begin
                    res_next   = g_yl;
                    match_next = 1'b1;
                end
                else if (count_reg < CW'(2))
                begin
                    stat_next = slti_pkg::ST_TOO_FEW;
                    res_next  = (count_reg == CW'(1)) ? g_yl : '0;
                end
                else if (g_xl == g_xu)
                begin
                    stat_next = slti_pkg::ST_DEGENERATE;
                    res_next  = above_reg ? g_yu : g_yl;
                end
                else
                begin
                    stat_next  = (below_reg || above_reg) ? slti_pkg::ST_EXTRAP
                                                          : slti_pkg::ST_OK;
                    state_next = slti_pkg::S_MUL;
                end
            end
            slti_pkg::S_MUL:   state_next = slti_pkg::S_DIVGO;
            slti_pkg::S_DIVGO: state_next = slti_pkg::S_DIV;
            slti_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = slti_pkg::S_FIN;
                    if (sum > SAT_MAX)
                        res_next = SAT_MAX[VALUE_WIDTH-1:0];
                    else if (sum < SAT_MIN)
                        res_next = SAT_MIN[VALUE_WIDTH-1:0];
                    else
                        res_next = sum[VALUE_WIDTH-1:0];
                end
            end
            slti_pkg::S_FIN:
            begin
                if (fin_go)
                    state_next = slti_pkg::S_IDLE;
            end
            default: state_next = slti_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slti_pkg::S_IDLE;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            below_reg     <= 1'b0;
            above_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == slti_pkg::S_SEL)
            begin
                hit_reg   <= ctrl.hit;
                below_reg <= ctrl.below;
                above_reg <= ctrl.above;
            end
            if (state_reg == slti_pkg::S_FIN && fin_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        match_reg <= match_next;
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            key_reg  <= key_x;
            val_reg  <= value_y;
        end
        if (state_reg == slti_pkg::S_GATHER)
        begin
            xl_reg <= g_xl;
            xu_reg <= g_xu;
            yl_reg <= g_yl;
            yu_reg <= g_yu;
        end
        if (state_reg == slti_pkg::S_MUL)
        begin
            prod_reg <= NW'((DW'(key_reg) - DW'(xl_reg)) *
                            ((VALUE_WIDTH+1)'(yu_reg) - (VALUE_WIDTH+1)'(yl_reg)));
            den_reg  <= DW'(xu_reg) - DW'(xl_reg);
        end
        if (state_reg == slti_pkg::S_FIN && fin_go)
        begin
            out_y_reg     <= res_reg;
            out_stat_reg  <= stat_reg;
            out_match_reg <= match_reg;
            out_cnt_reg   <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_y  = out_y_reg;
    assign status    = out_stat_reg;
    assign matched   = out_match_reg;
    assign entries   = out_cnt_reg;

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("point count beyond table depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slti_pkg::S_EXEC && func_reg == slti_pkg::FUNC_LOAD &&
         count_reg != DEPTH_C) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table");

    a_single_pick: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == slti_pkg::S_GATHER |-> $onehot0(cpick))
        else $error("more than one cell selected");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == slti_pkg::S_DIVGO |-> den_reg != '0)
        else $error("divide by zero segment");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sorted table linear interpolator
// Drives load, query, clear and unused-code requests with random idling on both channels.
// A scoreboard keeps its own sorted table, predicts each result and compares
// every field of the responses in order.
// ----------------------------------------------------------------------------

class interp_scoreboard;
    logic signed [15:0] tbl_x[64];
    logic signed [15:0] tbl_y[64];
    int count;
    logic signed [15:0] want_y[$];
    logic [2:0]         want_status[$];
    logic               want_matched[$];
    logic [6:0]         want_entries[$];
    int errors;
    int checked;
    int n_extrap, n_degen, n_match, n_full, n_few;

    function new();
        count = 0;
        errors = 0;
        checked = 0;
        n_extrap = 0; n_degen = 0; n_match = 0; n_full = 0; n_few = 0;
    endfunction

    function logic signed [15:0] along(int lo, logic signed [15:0] q);
        longint xl, xu, yl, yu, v;
        xl = tbl_x[lo]; xu = tbl_x[lo+1];
        yl = tbl_y[lo]; yu = tbl_y[lo+1];
        v = yl + ((longint'(q) - xl) * (yu - yl)) / (xu - xl);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function void note_request(logic [1:0] f, logic signed [15:0] k, logic signed [15:0] v);
        logic signed [15:0] r;
        logic [2:0] st;
        logic m;
        int pos, hit, lo;
        r = 0; st = slti_pkg::ST_OK; m = 0;
        if (f == slti_pkg::FUNC_LOAD) begin
            if (count >= 64) begin
                st = slti_pkg::ST_FULL;
                n_full++;
            end
            else begin
                pos = 0;
                while (pos < count && tbl_x[pos] <= k) pos++;
                for (int i = count; i > pos; i--) begin
                    tbl_x[i] = tbl_x[i-1];
                    tbl_y[i] = tbl_y[i-1];
                end
                tbl_x[pos] = k;
                tbl_y[pos] = v;
                count++;
            end
        end
        else if (f == slti_pkg::FUNC_QUERY) begin
            hit = -1;
            for (int i = 0; i < count; i++)
                if (hit < 0 && tbl_x[i] == k) hit = i;
            if (hit >= 0) begin
                r = tbl_y[hit];
                m = 1;
                n_match++;
            end
            else if (count < 2) begin
                st = slti_pkg::ST_TOO_FEW;
                r = (count == 1) ? tbl_y[0] : 16'sd0;
                n_few++;
            end
            else if (k < tbl_x[0]) begin
                if (tbl_x[0] == tbl_x[1]) begin
                    st = slti_pkg::ST_DEGENERATE; r = tbl_y[0]; n_degen++;
                end
                else begin
                    st = slti_pkg::ST_EXTRAP; r = along(0, k); n_extrap++;
                end
            end
            else if (k > tbl_x[count-1]) begin
                if (tbl_x[count-2] == tbl_x[count-1]) begin
                    st = slti_pkg::ST_DEGENERATE; r = tbl_y[count-1]; n_degen++;
                end
                else begin
                    st = slti_pkg::ST_EXTRAP; r = along(count-2, k); n_extrap++;
                end
            end
            else begin
                lo = 0;
                for (int i = 0; i + 1 < count; i++)
                    if (tbl_x[i] < k) lo = i;
                if (tbl_x[lo] == tbl_x[lo+1]) begin
                    st = slti_pkg::ST_DEGENERATE; r = tbl_y[lo]; n_degen++;
                end
                else
                    r = along(lo, k);
            end
        end
        else if (f == slti_pkg::FUNC_CLEAR)
            count = 0;
        want_y = {want_y, r};
        want_status = {want_status, st};
        want_matched = {want_matched, m};
        want_entries = {want_entries, 7'(count)};
    endfunction

    function void check_result(logic signed [15:0] y, logic [2:0] st, logic m, logic [6:0] e);
        logic signed [15:0] ey;
        logic [2:0] est;
        logic em;
        logic [6:0] ee;
        checked++;
        if (want_y.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result y=%0d status=%0d", y, st);
            return;
        end
        ey = want_y.pop_front();
        est = want_status.pop_front();
        em = want_matched.pop_front();
        ee = want_entries.pop_front();
        if (y !== ey || st !== est || m !== em || e !== ee) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: result %0d: exp y=%0d st=%0d m=%0d n=%0d",
                         checked, ey, est, em, ee,
                         " got y=%0d st=%0d m=%0d n=%0d", y, st, m, e);
        end
    endfunction

    function int pending();
        return want_y.size();
    endfunction
endclass

module testbench;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] func;
    logic signed [15:0] key_x;
    logic signed [15:0] value_y;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] result_y;
    logic [2:0] status;
    logic matched;
    logic [6:0] entries;

    interp_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    longint cycles;
    int sent;

    sorted_table_linear_interpolator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .key_x(key_x), .value_y(value_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_y(result_y), .status(status), .matched(matched), .entries(entries)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: sample at edge, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                board.check_result(result_y, status, matched, entries);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays high across back-to-back requests; dropped only on idle cycles
    task automatic send_request(logic [1:0] f, logic signed [15:0] k, logic signed [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key_x <= k;
        value_y <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(f, k, v);
        sent++;
    endtask

    // keys mostly drawn from a narrow window so queries hit, bracket and duplicate
    function automatic logic signed [15:0] pick_key();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'(16'sh7fff - $urandom_range(3));
            2: return 16'(16'sh8000 + $urandom_range(3));
            default: return $signed(16'($urandom_range(60))) - 16'sd30;
        endcase
    endfunction

    task automatic random_phase(int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 2)
                send_request(slti_pkg::FUNC_CLEAR, 16'($urandom), 16'($urandom));
            else if (kind < 3)
                send_request(FUNC_UNUSED, 16'($urandom), 16'($urandom));
            else if (kind < 45 || board.count < 2)
                send_request(slti_pkg::FUNC_LOAD, pick_key(), 16'($urandom));
            else
                send_request(slti_pkg::FUNC_QUERY, pick_key(), 16'($urandom));
            // keep the table from sitting full
            if (board.count == 64 && $urandom_range(3) == 0)
                send_request(slti_pkg::FUNC_CLEAR, 16'sd0, 16'sd0);
        end
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        func = slti_pkg::FUNC_CLEAR;
        key_x = 0;
        value_y = 0;
        send_idle_pct = 7;
        recv_idle_pct = 67;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, single point, extremes, saturation, degenerate ends
        send_request(slti_pkg::FUNC_QUERY, 16'sd5, 16'sd0);
        send_request(slti_pkg::FUNC_LOAD, 16'sd0, 16'sh7fff);
        send_request(slti_pkg::FUNC_QUERY, 16'sd0, 16'sd0);
        send_request(slti_pkg::FUNC_QUERY, 16'sd9, 16'sd0);
        send_request(slti_pkg::FUNC_LOAD, 16'sd1, 16'sh8000);
        send_request(slti_pkg::FUNC_QUERY, 16'sh7fff, 16'sd0);
        send_request(slti_pkg::FUNC_QUERY, 16'sh8000, 16'sd0);
        send_request(FUNC_UNUSED, 16'shffff, 16'shffff);
        send_request(slti_pkg::FUNC_CLEAR, 16'sd0, 16'sd0);
        send_request(slti_pkg::FUNC_LOAD, 16'sd10, 16'sd100);
        send_request(slti_pkg::FUNC_LOAD, 16'sd10, 16'sd200);
        send_request(slti_pkg::FUNC_LOAD, 16'sd20, 16'sd300);
        send_request(slti_pkg::FUNC_LOAD, 16'sd20, 16'sd400);
        send_request(slti_pkg::FUNC_LOAD, 16'sd30, 16'sd500);
        send_request(slti_pkg::FUNC_QUERY, 16'sd10, 16'sd0);
        send_request(slti_pkg::FUNC_QUERY, 16'sd5, 16'sd0);
        send_request(slti_pkg::FUNC_QUERY, 16'sd15, 16'sd0);
        send_request(slti_pkg::FUNC_QUERY, 16'sd25, 16'sd0);
        send_request(slti_pkg::FUNC_QUERY, 16'sd40, 16'sd0);
        send_request(slti_pkg::FUNC_LOAD, 16'sd30, 16'sd600);
        send_request(slti_pkg::FUNC_QUERY, 16'sd40, 16'sd0);
        for (int i = 0; i < 60; i++)
            send_request(slti_pkg::FUNC_LOAD, 16'(i * 7), 16'($urandom));
        send_request(slti_pkg::FUNC_QUERY, 16'sd3, 16'sd0);

        random_phase(456);
        send_idle_pct = 67;
        recv_idle_pct = 7;
        random_phase(456);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(456);
        in_valid <= 1'b0;

        while (board.pending() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d requests; %0d matches, %0d extrapolated, %0d degenerate,",
                 sent, board.n_match, board.n_extrap, board.n_degen);
        $display("%0d table-full loads, %0d too-few queries checked.", board.n_full, board.n_few);
        if (board.errors == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
